[rtl/poa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// poa_pkg
// Shared sizes, command codes and helper functions of the oblivious RAM engine.
// ----------------------------------------------------------------------------
package poa_pkg;

   localparam int LEVELS      = 4;
   localparam int SLOTS       = 4;
   localparam int STASH_DEPTH = 48;
   localparam int DATA_BITS   = 64;

   localparam int ID_W         = 6;
   localparam int BLOCK_COUNT  = 1 << ID_W;
   localparam int LEAF_W       = LEVELS - 1;
   localparam int BKT_W        = LEVELS;
   localparam int BUCKET_COUNT = (1 << LEVELS) - 1;
   localparam int TREE_SLOTS   = BUCKET_COUNT * SLOTS;
   localparam int TREE_AW      = $clog2(TREE_SLOTS);
   localparam int STASH_AW     = $clog2(STASH_DEPTH);
   localparam int LVL_W        = $clog2(LEVELS);
   localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W        = $clog2(SLOTS + 1);

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_REMAP,
      OP_PATH_RD,
      OP_PATH_LOC,
      OP_PATH_PUT,
      OP_WR_LOC,
      OP_WR_PUT,
      OP_RD_LOC,
      OP_RD_PAY,
      OP_RD_DONE,
      OP_SCAN,
      OP_DRAIN,
      OP_EV_RD,
      OP_EV_WR,
      OP_RESP
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [LVL_W-1:0]    level;
      logic [SLOT_W-1:0]   slot;
      logic [STASH_AW-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic slot_valid;
      logic is_write;
   } dp_stat_type;

   function automatic logic [BKT_W-1:0] bucket_at(input logic [LVL_W-1:0] lvl,
                                                  input logic [LEAF_W-1:0] leaf);
      logic [BKT_W-1:0] full;
      full = {1'b1, leaf};
      return full >> (LEAF_W - int'(lvl));
   endfunction

   function automatic logic [TREE_AW-1:0] slot_addr(input logic [BKT_W-1:0] bkt,
                                                    input logic [SLOT_W-1:0] slot);
      return TREE_AW'((int'(bkt) - 1) * SLOTS + int'(slot));
   endfunction

endpackage
`default_nettype wire

[rtl/path_oram_access.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// path_oram_access
// Tree-based oblivious block store: remap, path read, stash update, eviction.
// ----------------------------------------------------------------------------
// One transaction at a time. A transaction does a map lookup, then visits
// each of the 16 path slots, with a read, locate and put for an occupied
// slot and a read alone for an empty one; a write then locates and puts its
// data, and the read-out locates, fetches and latches the payload. Per level
// follow a scan of all 48 stash entries, one entry per cycle, a pipeline
// drain and a refill of the bucket; then the result is posted. The next
// request is taken while the previous response still waits on rsp_stall.
// State is cleared by valid bits at reset, so no clearing pass is needed.
module path_oram_access
   import poa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic [ID_W-1:0]      req_block_id,
   input  logic [DATA_BITS-1:0] req_write_data,
   input  logic [LEAF_W-1:0]    req_new_leaf,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DATA_BITS-1:0] rsp_read_data,
   output logic                 rsp_stash_overflow
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   poa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   poa_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_command        (req_command),
      .req_block_id       (req_block_id),
      .req_write_data     (req_write_data),
      .req_new_leaf       (req_new_leaf),
      .rsp_read_data      (rsp_read_data),
      .rsp_stash_overflow (rsp_stash_overflow)
   );

endmodule
`default_nettype wire

[rtl/poa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// poa_ctrl
// Sequencer: path read, stash update, read-out, eviction and response.
// ----------------------------------------------------------------------------
module poa_ctrl
   import poa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REMAP,
      ST_PATH_RD,
      ST_PATH_LOC,
      ST_PATH_PUT,
      ST_WR_LOC,
      ST_WR_PUT,
      ST_RD_LOC,
      ST_RD_PAY,
      ST_RD_DONE,
      ST_SCAN,
      ST_DRAIN,
      ST_EV_RD,
      ST_EV_WR,
      ST_DONE
   } state_type;

   state_type           state_ff;
   logic [LVL_W-1:0]    level_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [STASH_AW-1:0] idx_ff;
   logic                rsp_valid_ff;
   logic                out_free;
   logic                last_slot;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_slot = (slot_ff == SLOT_W'(SLOTS - 1));
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.level = level_ff;
      cmd.slot  = slot_ff;
      cmd.idx   = idx_ff;
      unique case (state_ff)
         ST_IDLE:     cmd.op = req_valid ? OP_LOAD : OP_IDLE;
         ST_REMAP:    cmd.op = OP_REMAP;
         ST_PATH_RD:  cmd.op = OP_PATH_RD;
         ST_PATH_LOC: cmd.op = OP_PATH_LOC;
         ST_PATH_PUT: cmd.op = OP_PATH_PUT;
         ST_WR_LOC:   cmd.op = OP_WR_LOC;
         ST_WR_PUT:   cmd.op = OP_WR_PUT;
         ST_RD_LOC:   cmd.op = OP_RD_LOC;
         ST_RD_PAY:   cmd.op = OP_RD_PAY;
         ST_RD_DONE:  cmd.op = OP_RD_DONE;
         ST_SCAN:     cmd.op = OP_SCAN;
         ST_DRAIN:    cmd.op = OP_DRAIN;
         ST_EV_RD:    cmd.op = OP_EV_RD;
         ST_EV_WR:    cmd.op = OP_EV_WR;
         ST_DONE:     cmd.op = out_free ? OP_RESP : OP_IDLE;
         default:     cmd.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         slot_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff) inside
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_REMAP;
               end
            end
            ST_REMAP: begin
               level_ff <= '0;
               slot_ff  <= '0;
               state_ff <= ST_PATH_RD;
            end
            ST_PATH_RD, ST_PATH_PUT: begin
               if (state_ff == ST_PATH_RD && stat.slot_valid) begin
                  state_ff <= ST_PATH_LOC;
               end else if (!last_slot) begin
                  slot_ff  <= slot_ff + SLOT_W'(1);
                  state_ff <= ST_PATH_RD;
               end else if (level_ff != LVL_W'(LEVELS - 1)) begin
                  slot_ff  <= '0;
                  level_ff <= level_ff + LVL_W'(1);
                  state_ff <= ST_PATH_RD;
               end else begin
                  slot_ff  <= '0;
                  state_ff <= stat.is_write ? ST_WR_LOC : ST_RD_LOC;
               end
            end
            ST_PATH_LOC: state_ff <= ST_PATH_PUT;
            ST_WR_LOC:   state_ff <= ST_WR_PUT;
            ST_WR_PUT:   state_ff <= ST_RD_LOC;
            ST_RD_LOC:   state_ff <= ST_RD_PAY;
            ST_RD_PAY:   state_ff <= ST_RD_DONE;
            ST_RD_DONE: begin
               level_ff <= LVL_W'(LEVELS - 1);
               slot_ff  <= '0;
               idx_ff   <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (idx_ff == STASH_AW'(STASH_DEPTH - 1)) begin
                  idx_ff   <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  idx_ff <= idx_ff + STASH_AW'(1);
               end
            end
            ST_DRAIN: begin
               if (idx_ff == STASH_AW'(1)) begin
                  idx_ff   <= '0;
                  slot_ff  <= '0;
                  state_ff <= ST_EV_RD;
               end else begin
                  idx_ff <= idx_ff + STASH_AW'(1);
               end
            end
            ST_EV_RD: state_ff <= ST_EV_WR;
            ST_EV_WR: begin
               if (!last_slot) begin
                  slot_ff  <= slot_ff + SLOT_W'(1);
                  state_ff <= ST_EV_RD;
               end else if (level_ff != '0) begin
                  level_ff <= level_ff - LVL_W'(1);
                  slot_ff  <= '0;
                  idx_ff   <= '0;
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

[rtl/poa_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// poa_dp
// Datapath: position map, bucket tree, stash, eviction scan and result regs.
// ----------------------------------------------------------------------------
module poa_dp
   import poa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic                 req_command,
   input  logic [ID_W-1:0]      req_block_id,
   input  logic [DATA_BITS-1:0] req_write_data,
   input  logic [LEAF_W-1:0]    req_new_leaf,
   output logic [DATA_BITS-1:0] rsp_read_data,
   output logic                 rsp_stash_overflow
);

   logic [LEAF_W-1:0]    pmap_mem [BLOCK_COUNT];
   logic [ID_W-1:0]      tree_id_mem [TREE_SLOTS];
   logic [DATA_BITS-1:0] tree_pay_mem [TREE_SLOTS];
   logic [ID_W-1:0]      stash_id_mem [STASH_DEPTH];
   logic [DATA_BITS-1:0] stash_pay_mem [STASH_DEPTH];
   logic [STASH_AW-1:0]  loc_mem [BLOCK_COUNT];

   logic [BLOCK_COUNT-1:0] pm_vld_ff;
   logic [TREE_SLOTS-1:0]  tree_vld_ff;
   logic [STASH_DEPTH-1:0] occ_ff;
   logic [BLOCK_COUNT-1:0] present_ff;

   logic                 is_write_ff;
   logic [ID_W-1:0]      id_ff;
   logic [DATA_BITS-1:0] wdata_ff;
   logic [LEAF_W-1:0]    fresh_ff;
   logic [LEAF_W-1:0]    old_leaf_ff;
   logic                 overflow_ff;
   logic                 hit_ff;
   logic [DATA_BITS-1:0] rdata_ff;
   logic [DATA_BITS-1:0] rsp_read_data_ff;
   logic                 rsp_overflow_ff;

   logic [LEAF_W-1:0]    pm_q;
   logic                 pm_vq;
   logic [ID_W-1:0]      tid_q;
   logic [DATA_BITS-1:0] tpay_q;
   logic [STASH_AW-1:0]  loc_q;
   logic [ID_W-1:0]      sid_q;
   logic [DATA_BITS-1:0] spay_q;

   logic                 s1_v_ff, s2_v_ff;
   logic [STASH_AW-1:0]  s1_i_ff, s2_i_ff;
   logic [STASH_AW-1:0]  chosen_ff [SLOTS];
   logic [CNT_W-1:0]     cnt_ff;
   logic                 ev_v_ff;
   logic [STASH_AW-1:0]  ev_k_ff;

   logic [TREE_AW-1:0]   tree_addr;
   logic [ID_W-1:0]      pm_addr;
   logic [LEAF_W-1:0]    pm_leaf;
   logic [ID_W-1:0]      loc_addr;
   logic                 put_active, put_hit, put_new, put_drop;
   logic [ID_W-1:0]      put_id;
   logic [DATA_BITS-1:0] put_data;
   logic                 free_any;
   logic [STASH_AW-1:0]  free_idx;
   logic                 match;
   logic [CNT_W-1:0]     pick_pos;
   logic                 ev_take;
   logic [STASH_AW-1:0]  ev_k;
   logic [STASH_AW-1:0]  sid_raddr, spay_raddr, spay_waddr;

   assign tree_addr       = slot_addr(bucket_at(cmd.level, old_leaf_ff), cmd.slot);
   assign stat.slot_valid = tree_vld_ff[tree_addr];
   assign stat.is_write   = is_write_ff;

   assign pm_addr = (cmd.op == OP_LOAD) ? req_block_id : sid_q;
   assign pm_leaf = pm_vq ? pm_q : '0;

   assign put_active = (cmd.op == OP_PATH_PUT) || (cmd.op == OP_WR_PUT);
   assign put_id     = (cmd.op == OP_PATH_PUT) ? tid_q : id_ff;
   assign put_data   = (cmd.op == OP_PATH_PUT) ? tpay_q : wdata_ff;
   assign put_hit    = put_active && present_ff[put_id];
   assign put_new    = put_active && !present_ff[put_id] && free_any;
   assign put_drop   = put_active && !present_ff[put_id] && !free_any;
   assign loc_addr   = (cmd.op == OP_PATH_LOC) ? tid_q : id_ff;
   assign spay_waddr = put_hit ? loc_q : free_idx;

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = STASH_DEPTH - 1; i >= 0; i--) begin
         if (!occ_ff[i]) begin
            free_any = 1'b1;
            free_idx = STASH_AW'(i);
         end
      end
   end

   assign match = s2_v_ff && (cnt_ff < CNT_W'(SLOTS)) &&
                  (bucket_at(cmd.level, pm_leaf) == bucket_at(cmd.level, old_leaf_ff));

   assign pick_pos   = cnt_ff - CNT_W'(1) - CNT_W'(cmd.slot);
   assign ev_take    = CNT_W'(cmd.slot) < cnt_ff;
   assign ev_k       = chosen_ff[pick_pos[SLOT_W-1:0]];
   assign sid_raddr  = (cmd.op == OP_EV_RD) ? ev_k : cmd.idx;
   assign spay_raddr = (cmd.op == OP_EV_RD) ? ev_k : loc_q;

   // memories
   always_ff @(posedge clock) begin
      pm_q   <= pmap_mem[pm_addr];
      pm_vq  <= pm_vld_ff[pm_addr];
      if (cmd.op == OP_REMAP) begin
         pmap_mem[id_ff] <= fresh_ff;
      end
      tid_q  <= tree_id_mem[tree_addr];
      tpay_q <= tree_pay_mem[tree_addr];
      if (cmd.op == OP_EV_WR && ev_v_ff) begin
         tree_id_mem[tree_addr]  <= sid_q;
         tree_pay_mem[tree_addr] <= spay_q;
      end
      loc_q <= loc_mem[loc_addr];
      if (put_new) begin
         loc_mem[put_id] <= free_idx;
      end
      sid_q  <= stash_id_mem[sid_raddr];
      spay_q <= stash_pay_mem[spay_raddr];
      if (put_hit || put_new) begin
         stash_pay_mem[spay_waddr] <= put_data;
      end
      if (put_new) begin
         stash_id_mem[free_idx] <= put_id;
      end
   end

   // valid bits and scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         pm_vld_ff   <= '0;
         tree_vld_ff <= '0;
         occ_ff      <= '0;
         present_ff  <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         if (cmd.op == OP_REMAP) begin
            pm_vld_ff[id_ff] <= 1'b1;
         end
         if (cmd.op == OP_PATH_RD) begin
            tree_vld_ff[tree_addr] <= 1'b0;
         end
         if (cmd.op == OP_EV_WR) begin
            tree_vld_ff[tree_addr] <= ev_v_ff;
            if (ev_v_ff) begin
               occ_ff[ev_k_ff]   <= 1'b0;
               present_ff[sid_q] <= 1'b0;
            end
         end
         if (put_new) begin
            occ_ff[free_idx]   <= 1'b1;
            present_ff[put_id] <= 1'b1;
         end
         s1_v_ff <= (cmd.op == OP_SCAN) && occ_ff[cmd.idx];
         s2_v_ff <= s1_v_ff;
         if (cmd.op == OP_SCAN && cmd.idx == '0) begin
            cnt_ff <= '0;
         end else if (match) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   // transaction payload
   always_ff @(posedge clock) begin
      s1_i_ff <= cmd.idx;
      s2_i_ff <= s1_i_ff;
      if (match) begin
         chosen_ff[cnt_ff[SLOT_W-1:0]] <= s2_i_ff;
      end
      if (cmd.op == OP_EV_RD) begin
         ev_v_ff <= ev_take;
         ev_k_ff <= ev_k;
      end
      if (cmd.op == OP_LOAD) begin
         is_write_ff <= req_command;
         id_ff       <= req_block_id;
         wdata_ff    <= req_write_data;
         fresh_ff    <= req_new_leaf;
         overflow_ff <= 1'b0;
      end else if (put_drop) begin
         overflow_ff <= 1'b1;
      end
      if (cmd.op == OP_REMAP) begin
         old_leaf_ff <= pm_leaf;
      end
      if (cmd.op == OP_RD_PAY) begin
         hit_ff <= present_ff[id_ff];
      end
      if (cmd.op == OP_RD_DONE) begin
         rdata_ff <= hit_ff ? spay_q : '0;
      end
      if (cmd.op == OP_RESP) begin
         rsp_read_data_ff <= rdata_ff;
         rsp_overflow_ff  <= overflow_ff;
      end
   end

   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_stash_overflow = rsp_overflow_ff;

`ifndef SYNTHESIS
   a_occ_matches_present: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_ff) == $countones(present_ff))
      else $error("stash occupancy and presence disagree");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SLOTS))
      else $error("eviction pick count beyond bucket size");
   a_evict_from_occupied: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EV_WR && ev_v_ff) |-> occ_ff[ev_k_ff])
      else $error("eviction of an empty stash entry");
`endif

endmodule
`default_nettype wire
